[sv/cdr_pkg.sv]
// Shared types, constants and helper functions for the captive DNS responder.
`timescale 1ns / 1ps
package cdr_pkg;

  typedef struct packed {
    logic [7:0] query_byte;
    logic       query_last;
  } query_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
    logic       dropped;
  } reply_t;

  typedef enum logic [2:0] {
    ST_RX,
    ST_CHECK,
    ST_DROP,
    ST_EMIT,
    ST_DRAIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_LABEL,
    PH_DONE
  } name_phase_t;

  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_RAM,
    SRC_FLAGS
  } byte_src_t;

  typedef struct packed {
    logic rx_en;
    logic idx_clear;
    logic issue;
    logic issue_drop;
  } cdr_cmd_t;

  typedef struct packed {
    logic last_accepted;
    logic drop;
    logic issue_last;
    logic adv;
    logic s1_busy;
  } cdr_status_t;

  localparam int          HDR_BYTES    = 12;
  localparam int          MIN_QUERY    = 13;
  localparam int          TAIL_LAST    = 15;
  localparam int          NUM_PATTERNS = 3;
  localparam logic [7:0]  HDR_FLAGS    = 8'h84;
  localparam logic [7:0]  NAME_PTR_HI  = 8'hC0;
  localparam logic [7:0]  NAME_PTR_LO  = 8'h0C;
  localparam logic [7:0]  TYPE_A       = 8'h01;
  localparam logic [7:0]  CLASS_IN     = 8'h01;
  localparam logic [7:0]  RDLENGTH     = 8'h04;
  localparam logic [7:0]  DOT_CHAR     = 8'h2E;
  localparam logic [31:0] ADDR_RESET   = 32'hC0A80401;

  function automatic logic [7:0] pat_char(input logic [1:0] p, input logic [2:0] k);
    logic [7:0] c;
    c = 8'h00;
    case (p)
      2'd0: begin
        case (k)
          3'd0: c = "d";
          3'd1: c = "i";
          3'd2: c = "g";
          3'd3: c = "i";
          3'd4: c = "t";
          default: c = 8'h00;
        endcase
      end
      2'd1: begin
        case (k)
          3'd0: c = "l";
          3'd1: c = "e";
          3'd2: c = "d";
          default: c = 8'h00;
        endcase
      end
      2'd2: begin
        case (k)
          3'd0: c = "L";
          3'd1: c = "E";
          3'd2: c = "D";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] pat_len(input logic [1:0] p);
    return (p == 2'd0) ? 3'd5 : 3'd3;
  endfunction

  // Answer section after the echoed question: pointer, type, class, TTL, length, address.
  function automatic logic [7:0] tail_byte(input logic [3:0] j, input logic [31:0] addr);
    logic [7:0] b;
    b = 8'h00;
    case (j)
      4'd0:    b = NAME_PTR_HI;
      4'd1:    b = NAME_PTR_LO;
      4'd3:    b = TYPE_A;
      4'd5:    b = CLASS_IN;
      4'd11:   b = RDLENGTH;
      4'd12:   b = addr[31:24];
      4'd13:   b = addr[23:16];
      4'd14:   b = addr[15:8];
      4'd15:   b = addr[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[sv/cdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/cdr_ctrl.sv]
// Controller state machine: receive, decide, emit reply or drop, drain.
`timescale 1ns / 1ps
module cdr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  cdr_pkg::cdr_status_t status,
  output cdr_pkg::cdr_cmd_t    cmd
);

  cdr_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdr_pkg::ST_RX;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      cdr_pkg::ST_RX: begin
        if (status.last_accepted) state_next = cdr_pkg::ST_CHECK;
      end
      cdr_pkg::ST_CHECK: begin
        state_next = status.drop ? cdr_pkg::ST_DROP : cdr_pkg::ST_EMIT;
      end
      cdr_pkg::ST_DROP: begin
        if (status.adv) state_next = cdr_pkg::ST_DRAIN;
      end
      cdr_pkg::ST_EMIT: begin
        if (status.adv && status.issue_last) state_next = cdr_pkg::ST_DRAIN;
      end
      cdr_pkg::ST_DRAIN: begin
        if (!status.s1_busy) state_next = cdr_pkg::ST_RX;
      end
      default: state_next = cdr_pkg::ST_RX;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      cdr_pkg::ST_RX:    cmd.rx_en = 1'b1;
      cdr_pkg::ST_CHECK: cmd.idx_clear = 1'b1;
      cdr_pkg::ST_DROP: begin
        cmd.issue      = status.adv;
        cmd.issue_drop = 1'b1;
      end
      cdr_pkg::ST_EMIT:  cmd.issue = status.adv;
      cdr_pkg::ST_DRAIN: cmd = '0;
      default:           cmd = '0;
    endcase
  end

endmodule

[sv/cdr_dp.sv]
// Datapath: query store, name parser and matchers, reply sequencer and output stage.
`timescale 1ns / 1ps
module cdr_dp #(
  parameter int QUERY_BYTES = 48,
  parameter int NAME_CHARS  = 29
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cdr_pkg::cdr_cmd_t    cmd,
  output cdr_pkg::cdr_status_t status,
  input  logic                 query_valid,
  input  cdr_pkg::query_t      query,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data,
  output logic                 reply_valid,
  input  logic                 reply_ready,
  output cdr_pkg::reply_t      reply
);

  localparam int CNT_W  = $clog2(QUERY_BYTES + 1);
  localparam int ADDR_W = $clog2(QUERY_BYTES);
  localparam int IDX_W  = $clog2(QUERY_BYTES + 16);
  localparam int NL_W   = $clog2(NAME_CHARS + 1);

  logic [31:0]            answer_address;

  logic [CNT_W-1:0]       byte_count, byte_count_next;
  logic [7:0]             label_remaining, label_remaining_next;
  cdr_pkg::name_phase_t   name_phase, name_phase_next, eff_phase;
  logic [NL_W-1:0]        name_length, name_length_next;
  logic [2:0]             pattern_progress [cdr_pkg::NUM_PATTERNS];
  logic [2:0]             pattern_progress_next [cdr_pkg::NUM_PATTERNS];
  logic                   name_matched, name_matched_next;
  logic                   query_invalid, query_invalid_next;
  logic                   name_overflow;
  logic                   ap_en;
  logic [7:0]             ap_char;
  logic                   accept, store_full;

  logic [CNT_W-1:0]       reply_len;
  logic                   drop_flag;

  logic [IDX_W-1:0]       k;
  logic [3:0]             tail_j;
  cdr_pkg::byte_src_t     iss_src;
  logic [7:0]             iss_const;
  logic [ADDR_W-1:0]      iss_addr;
  logic                   iss_last;
  logic                   adv;

  logic                   s1_valid;
  cdr_pkg::byte_src_t     s1_src;
  logic [7:0]             s1_const;
  logic                   s1_last;
  logic                   s1_drop;
  logic [7:0]             rdata;
  logic [7:0]             out_byte;

  assign accept     = query_valid && cmd.rx_en;
  assign store_full = (byte_count >= CNT_W'(QUERY_BYTES));
  assign eff_phase  = (name_phase == cdr_pkg::PH_HEADER &&
                       byte_count == CNT_W'(cdr_pkg::HDR_BYTES)) ?
                      cdr_pkg::PH_LENGTH : name_phase;

  cdr_ram #(.WIDTH(8), .DEPTH(QUERY_BYTES)) u_store (
    .clk   (clk),
    .we    (accept && !store_full),
    .waddr (byte_count[ADDR_W-1:0]),
    .wdata (query.query_byte),
    .re    (adv),
    .raddr (iss_addr),
    .rdata (rdata)
  );

  // Name parser
  always_comb begin
    byte_count_next      = byte_count;
    label_remaining_next = label_remaining;
    name_phase_next      = name_phase;
    query_invalid_next   = query_invalid;
    ap_en                = 1'b0;
    ap_char              = query.query_byte;
    if (accept) begin
      if (store_full) begin
        query_invalid_next = 1'b1;
      end else begin
        byte_count_next = byte_count + CNT_W'(1);
        if (!query_invalid) begin
          unique case (eff_phase) inside
            cdr_pkg::PH_LENGTH: begin
              if (query.query_byte == 8'h00) begin
                name_phase_next = cdr_pkg::PH_DONE;
              end else begin
                ap_en                = (name_length != '0);
                ap_char              = cdr_pkg::DOT_CHAR;
                label_remaining_next = query.query_byte;
                name_phase_next      = cdr_pkg::PH_LABEL;
              end
            end
            cdr_pkg::PH_LABEL: begin
              if (query.query_byte == 8'h00) begin
                name_phase_next = cdr_pkg::PH_DONE;
              end else begin
                ap_en                = 1'b1;
                label_remaining_next = label_remaining - 8'd1;
                if (label_remaining == 8'd1) name_phase_next = cdr_pkg::PH_LENGTH;
              end
            end
            cdr_pkg::PH_HEADER, cdr_pkg::PH_DONE: begin
              name_phase_next = name_phase;
            end
            default: name_phase_next = name_phase;
          endcase
        end
      end
    end
  end

  // Pattern matchers, one per pattern
  always_comb begin
    logic [2:0] kn;
    kn                = '0;
    name_overflow     = 1'b0;
    name_length_next  = name_length;
    name_matched_next = name_matched;
    for (int p = 0; p < cdr_pkg::NUM_PATTERNS; p++) begin
      pattern_progress_next[p] = pattern_progress[p];
    end
    if (ap_en) begin
      if (name_length >= NL_W'(NAME_CHARS)) begin
        name_overflow = 1'b1;
      end else begin
        name_length_next = name_length + NL_W'(1);
        for (int p = 0; p < cdr_pkg::NUM_PATTERNS; p++) begin
          if (pattern_progress[p] < cdr_pkg::pat_len(2'(p)) &&
              ap_char == cdr_pkg::pat_char(2'(p), pattern_progress[p])) begin
            kn = pattern_progress[p] + 3'd1;
          end else begin
            kn = (ap_char == cdr_pkg::pat_char(2'(p), 3'd0)) ? 3'd1 : 3'd0;
          end
          if (kn >= cdr_pkg::pat_len(2'(p))) begin
            name_matched_next = 1'b1;
            kn = 3'd0;
          end
          pattern_progress_next[p] = kn;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && query.query_last)) begin
      byte_count      <= '0;
      label_remaining <= '0;
      name_phase      <= cdr_pkg::PH_HEADER;
      name_length     <= '0;
      name_matched    <= 1'b0;
      query_invalid   <= 1'b0;
      for (int p = 0; p < cdr_pkg::NUM_PATTERNS; p++) begin
        pattern_progress[p] <= '0;
      end
    end else begin
      byte_count      <= byte_count_next;
      label_remaining <= label_remaining_next;
      name_phase      <= name_phase_next;
      name_length     <= name_length_next;
      name_matched    <= name_matched_next;
      query_invalid   <= query_invalid_next || name_overflow;
      for (int p = 0; p < cdr_pkg::NUM_PATTERNS; p++) begin
        pattern_progress[p] <= pattern_progress_next[p];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      answer_address <= cdr_pkg::ADDR_RESET;
      drop_flag      <= 1'b0;
    end else begin
      if (cfg_wr_en) answer_address <= cfg_wr_data;
      if (accept && query.query_last) begin
        reply_len <= byte_count_next;
        drop_flag <= query_invalid_next || name_overflow || !name_matched_next ||
                     (byte_count_next < CNT_W'(cdr_pkg::MIN_QUERY));
      end
    end
  end

  // Reply sequencer: index k walks header, echoed question, answer record
  assign tail_j = 4'(k - IDX_W'(reply_len));

  always_comb begin
    iss_src   = cdr_pkg::SRC_CONST;
    iss_const = 8'h00;
    iss_addr  = '0;
    iss_last  = (k == IDX_W'(reply_len) + IDX_W'(cdr_pkg::TAIL_LAST));
    if (k < IDX_W'(cdr_pkg::HDR_BYTES)) begin
      case (k[3:0]) inside
        4'd0: begin iss_src = cdr_pkg::SRC_RAM;   iss_addr = ADDR_W'(0); end
        4'd1: begin iss_src = cdr_pkg::SRC_RAM;   iss_addr = ADDR_W'(1); end
        4'd2: begin iss_src = cdr_pkg::SRC_FLAGS; iss_addr = ADDR_W'(2); end
        4'd4, 4'd6: begin iss_src = cdr_pkg::SRC_RAM; iss_addr = ADDR_W'(4); end
        4'd5, 4'd7: begin iss_src = cdr_pkg::SRC_RAM; iss_addr = ADDR_W'(5); end
        default: iss_src = cdr_pkg::SRC_CONST;
      endcase
    end else if (k < IDX_W'(reply_len)) begin
      iss_src  = cdr_pkg::SRC_RAM;
      iss_addr = k[ADDR_W-1:0];
    end else begin
      iss_const = cdr_pkg::tail_byte(tail_j, answer_address);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clear) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + IDX_W'(1);
    end
  end

  // Read stage and output register
  assign adv = !reply_valid || reply_ready;

  always_comb begin
    case (s1_src)
      cdr_pkg::SRC_RAM:   out_byte = rdata;
      cdr_pkg::SRC_FLAGS: out_byte = cdr_pkg::HDR_FLAGS | {7'b0, rdata[0]};
      default:            out_byte = s1_const;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      reply_valid <= 1'b0;
    end else if (adv) begin
      s1_valid    <= cmd.issue;
      reply_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_src   <= cmd.issue_drop ? cdr_pkg::SRC_CONST : iss_src;
      s1_const <= cmd.issue_drop ? 8'h00 : iss_const;
      s1_last  <= cmd.issue_drop || iss_last;
      s1_drop  <= cmd.issue_drop;
      reply.reply_byte <= out_byte;
      reply.reply_last <= s1_last;
      reply.dropped    <= s1_drop;
    end
  end

  assign status.last_accepted = accept && query.query_last;
  assign status.drop          = drop_flag;
  assign status.issue_last    = iss_last;
  assign status.adv           = adv;
  assign status.s1_busy       = s1_valid;

endmodule

[sv/captive_dns_responder.sv]
// Captive portal DNS responder top level.
//
// Query bytes enter on the query channel (query_valid/query_ready), one
// transaction per byte, query_last on the final byte. While a query is being
// received one byte is taken every cycle; the name is parsed and matched on
// the fly. After the last byte the reply channel (reply_valid/reply_ready)
// carries either one dropped transaction or L+16 reply bytes for an L-byte
// query, one per cycle when the receiver is ready, reply_last on the final one.
// After the last query byte is accepted the controller decides between reply and
// drop, then issues the results; reply bytes are read back from the query store
// (one write port, one read port) through a registered read stage and an output
// register. query_ready is low from the last query byte until every result has
// been issued into the output register.
// A stalled receiver freezes the read stage and output register; nothing is
// lost. Reset (rst, synchronous) empties the pipeline, clears the parser and
// restores answer_address to 192.168.4.1; cfg_wr_en writes it from cfg_wr_data.
`timescale 1ns / 1ps
module captive_dns_responder #(
  parameter int QUERY_BYTES = 48,
  parameter int NAME_CHARS  = 29
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            query_valid,
  output logic            query_ready,
  input  cdr_pkg::query_t query,
  output logic            reply_valid,
  input  logic            reply_ready,
  output cdr_pkg::reply_t reply,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data
);

  cdr_pkg::cdr_cmd_t    cmd;
  cdr_pkg::cdr_status_t status;

  assign query_ready = cmd.rx_en;

  cdr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  cdr_dp #(
    .QUERY_BYTES (QUERY_BYTES),
    .NAME_CHARS  (NAME_CHARS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .query_valid (query_valid),
    .query       (query),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .reply_valid (reply_valid),
    .reply_ready (reply_ready),
    .reply       (reply)
  );

endmodule

[sv/cdr_checker.sv]
// Port-level checker for the captive DNS responder, bound to the top level.
`timescale 1ns / 1ps
module cdr_checker (
  input logic            clk,
  input logic            rst,
  input logic            query_valid,
  input logic            query_ready,
  input cdr_pkg::query_t query,
  input logic            reply_valid,
  input logic            reply_ready,
  input cdr_pkg::reply_t reply
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !reply_valid)
    else $error("reply_valid set after reset");

  a_reply_hold: assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply_ready |=> reply_valid)
    else $error("reply transaction withdrawn");

  a_reply_stable: assert property (@(posedge clk) disable iff (rst)
    reply_valid && !reply_ready |=> $stable(reply))
    else $error("stalled reply changed");

  a_drop_form: assert property (@(posedge clk) disable iff (rst)
    reply_valid && reply.dropped |-> reply.reply_last && (reply.reply_byte == 8'h00))
    else $error("dropped result malformed");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    query_valid && query_ready && query.query_last |=> !query_ready)
    else $error("query taken right after last byte");

endmodule

bind captive_dns_responder cdr_checker u_cdr_checker (
  .clk         (clk),
  .rst         (rst),
  .query_valid (query_valid),
  .query_ready (query_ready),
  .query       (query),
  .reply_valid (reply_valid),
  .reply_ready (reply_ready),
  .reply       (reply)
);

[test/captive_dns_responder_test.sv]
// Self-checking testbench for captive_dns_responder against a behavioral reply predictor.
`timescale 1ns / 1ps
module captive_dns_responder_test;

  localparam int STORE_DEPTH = 48;
  localparam int NAME_LIMIT  = 29;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    cdr_pkg::query_t item;
    logic            drain_first;
  } pending_byte_t;

  logic            clk         = 1'b0;
  logic            rst         = 1'b1;
  logic            query_valid = 1'b0;
  logic            query_ready;
  cdr_pkg::query_t query       = '0;
  logic            reply_valid;
  logic            reply_ready = 1'b0;
  cdr_pkg::reply_t reply;
  logic            cfg_wr_en   = 1'b0;
  logic [31:0]     cfg_wr_data = '0;

  pending_byte_t   pending_bytes [$];
  cdr_pkg::reply_t reply_expect [$];
  logic [7:0]      draft [$];
  int              fail_count  = 0;
  int              cycle_count = 0;

  // predictor state
  logic [7:0]           shadow_store [STORE_DEPTH];
  int                   stored_count;
  int                   label_left;
  cdr_pkg::name_phase_t parse_phase;
  int                   text_length;
  int                   match_progress [3];
  bit                   pattern_seen;
  bit                   query_bad;
  logic [31:0]          answer_addr;
  string                patterns [3] = '{"digit", "led", "LED"};

  int send_gap;
  int tx_calm;
  int ready_hold;
  int rx_calm;
  int rx_seen;

  captive_dns_responder DUT (
    .clk         (clk),
    .rst         (rst),
    .query_valid (query_valid),
    .query_ready (query_ready),
    .query       (query),
    .reply_valid (reply_valid),
    .reply_ready (reply_ready),
    .reply       (reply),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void restart_query();
    stored_count = 0;
    label_left   = 0;
    parse_phase  = cdr_pkg::PH_HEADER;
    text_length  = 0;
    foreach (match_progress[p]) match_progress[p] = 0;
    pattern_seen = 1'b0;
    query_bad    = 1'b0;
  endfunction

  function automatic void add_name_char(logic [7:0] c);
    int k;
    if (text_length >= NAME_LIMIT) begin
      query_bad = 1'b1;
      return;
    end
    text_length++;
    for (int p = 0; p < 3; p++) begin
      k = match_progress[p];
      if (k < patterns[p].len() && c == 8'(patterns[p][k])) k++;
      else k = (c == 8'(patterns[p][0])) ? 1 : 0;
      if (k >= patterns[p].len()) begin
        pattern_seen = 1'b1;
        k = 0;
      end
      match_progress[p] = k;
    end
  endfunction

  function automatic void track_name(int idx, logic [7:0] q);
    if (parse_phase == cdr_pkg::PH_HEADER) begin
      if (idx != 12) return;
      parse_phase = cdr_pkg::PH_LENGTH;
    end
    if (parse_phase == cdr_pkg::PH_LENGTH) begin
      if (q == 8'h00) begin
        parse_phase = cdr_pkg::PH_DONE;
      end else begin
        if (text_length > 0) add_name_char(8'h2E);
        label_left  = q;
        parse_phase = cdr_pkg::PH_LABEL;
      end
    end else if (parse_phase == cdr_pkg::PH_LABEL) begin
      if (q == 8'h00) begin
        parse_phase = cdr_pkg::PH_DONE;
      end else begin
        add_name_char(q);
        label_left--;
        if (label_left == 0) parse_phase = cdr_pkg::PH_LENGTH;
      end
    end
  endfunction

  task automatic predict_reply(cdr_pkg::query_t item);
    logic [7:0]      out_bytes [$];
    logic [7:0]      head [12];
    logic [7:0]      tail [16];
    cdr_pkg::reply_t r;
    if (stored_count >= STORE_DEPTH) begin
      query_bad = 1'b1;
    end else begin
      shadow_store[stored_count] = item.query_byte;
      stored_count++;
      if (!query_bad) track_name(stored_count - 1, item.query_byte);
    end
    if (!item.query_last) return;
    if (query_bad || stored_count < 13 || !pattern_seen) begin
      r.reply_byte = 8'h00;
      r.reply_last = 1'b1;
      r.dropped    = 1'b1;
      reply_expect.push_back(r);
    end else begin
      head = '{shadow_store[0], shadow_store[1], 8'h84 | {7'b0, shadow_store[2][0]}, 8'h00,
               shadow_store[4], shadow_store[5], shadow_store[4], shadow_store[5],
               8'h00, 8'h00, 8'h00, 8'h00};
      tail = '{8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00,
               8'h00, 8'h04, answer_addr[31:24], answer_addr[23:16], answer_addr[15:8],
               answer_addr[7:0]};
      foreach (head[i]) out_bytes.push_back(head[i]);
      for (int i = 12; i < stored_count; i++) out_bytes.push_back(shadow_store[i]);
      foreach (tail[i]) out_bytes.push_back(tail[i]);
      foreach (out_bytes[i]) begin
        r.reply_byte = out_bytes[i];
        r.reply_last = (i == out_bytes.size() - 1);
        r.dropped    = 1'b0;
        reply_expect.push_back(r);
      end
    end
    restart_query();
  endtask

  // sender: one query byte per transaction
  always @(posedge clk) begin
    pending_byte_t next_byte;
    if (rst) begin
      query_valid <= 1'b0;
      query       <= '0;
      send_gap    = 0;
      tx_calm     = 0;
      answer_addr = 32'hC0A8_0401;
      restart_query();
    end else begin
      if (cfg_wr_en) answer_addr = cfg_wr_data;
      if (query_valid && query_ready) predict_reply(query);
      if (!query_valid || query_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          query_valid <= 1'b0;
        end else if (pending_bytes.size() > 0 &&
                     (!pending_bytes[0].drain_first || reply_expect.size() == 0)) begin
          next_byte = pending_bytes.pop_front();
          query_valid <= 1'b1;
          query       <= next_byte.item;
          if (tx_calm > 0) begin
            tx_calm--;
            send_gap = 0;
          end else if ($urandom_range(99) < 2) begin
            tx_calm  = 60;
            send_gap = 0;
          end else begin
            send_gap = idle_length();
          end
        end else begin
          query_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus two long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      reply_ready <= 1'b0;
      ready_hold  = 0;
      rx_calm     = 0;
      rx_seen     = 0;
    end else begin
      if (reply_valid && reply_ready) begin
        rx_seen++;
        if (rx_seen == 10 || rx_seen == 50) ready_hold = 400;
      end
      if (ready_hold == 0 && rx_calm == 0) begin
        if ($urandom_range(99) < 2) rx_calm = 80;
        else ready_hold = idle_length();
      end
      if (ready_hold > 0) begin
        ready_hold--;
        reply_ready <= 1'b0;
      end else begin
        if (rx_calm > 0) rx_calm--;
        reply_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cdr_pkg::reply_t want;
    if (!rst && reply_valid && reply_ready) begin
      if (reply_expect.size() == 0) begin
        $error("unexpected reply transaction: reply_byte %h reply_last %b dropped %b",
               reply.reply_byte, reply.reply_last, reply.dropped);
        fail_count++;
      end else begin
        want = reply_expect.pop_front();
        if (reply.reply_byte !== want.reply_byte) begin
          $error("reply_byte: expected %h, actual %h", want.reply_byte, reply.reply_byte);
          fail_count++;
        end
        if (reply.reply_last !== want.reply_last) begin
          $error("reply_last: expected %b, actual %b", want.reply_last, reply.reply_last);
          fail_count++;
        end
        if (reply.dropped !== want.dropped) begin
          $error("dropped: expected %b, actual %b", want.dropped, reply.dropped);
          fail_count++;
        end
      end
    end
  end

  function automatic void draft_random(int n);
    repeat (n) draft.push_back(8'($urandom_range(255)));
  endfunction

  function automatic void draft_chars(string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(8'(s[i]));
  endfunction

  function automatic void draft_label(string s);
    draft.push_back(8'(s.len()));
    draft_chars(s);
  endfunction

  task automatic send_draft(bit drain);
    pending_byte_t pb;
    foreach (draft[i]) begin
      pb.item.query_byte = draft[i];
      pb.item.query_last = (i == draft.size() - 1);
      pb.drain_first     = drain && (i == 0);
      pending_bytes.push_back(pb);
    end
    draft.delete();
  endtask

  task automatic wait_until_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || query_valid || reply_expect.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic set_answer_address(logic [31:0] v);
    wait_until_idle();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset address, pattern after a false start
    draft_random(12);
    draft_label("ddigit");
    send_draft(1'b0);
    // too short
    draft_random(12);
    send_draft(1'b0);
    // name text beyond the limit
    draft_random(12);
    draft_label("abcdefghijklmnopqrstuvwxyzledx");
    send_draft(1'b1);

    set_answer_address(32'hFFFF_FFFF);
    // label longer than the rest of the query
    draft_random(12);
    draft.push_back(8'h20);
    draft_chars("xLED");
    send_draft(1'b0);
    // one byte more than the store holds
    draft_random(12);
    draft_label("led");
    draft.push_back(8'h00);
    draft_random(32);
    send_draft(1'b0);

    wait_until_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/cdr_pkg.sv
sv/cdr_ram.sv
sv/cdr_ctrl.sv
sv/cdr_dp.sv
sv/captive_dns_responder.sv
sv/cdr_checker.sv
test/captive_dns_responder_test.sv
